>>> rtl/kps_pkg.sv
// kps_pkg: shared constants, codes and the scan token type for the keyframe sampler
// depends on nothing; used by every file in rtl

package kps_pkg;

   localparam int MAX_KEYS  = 64;
   localparam int KEY_IDX_W = $clog2(MAX_KEYS);
   localparam int COUNT_W   = 7;
   localparam int TIME_W    = 32;
   localparam int POS_W     = 32;
   localparam int NUM_W     = TIME_W + 16;

   // sample kinds
   localparam logic [1:0] KIND_EMPTY  = 2'd0;
   localparam logic [1:0] KIND_EXACT  = 2'd1;
   localparam logic [1:0] KIND_INTERP = 2'd2;
   localparam logic [1:0] KIND_HOLD   = 2'd3;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // scan modes
   localparam logic SCAN_FROM = 1'b0;
   localparam logic SCAN_TO   = 1'b1;

   typedef struct packed {
      logic                    valid;
      logic                    found;
      logic [TIME_W-1:0]       key_t;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } token_type;

endpackage

>>> rtl/kps_cell.sv
// kps_cell: one keyframe slot of the chain, stores a key and updates the passing token
// depends on kps_pkg

module kps_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [kps_pkg::KEY_IDX_W-1:0]        cell_id,
   input  logic [kps_pkg::COUNT_W-1:0]          key_num,
   input  logic                                 wr_en,
   input  logic [kps_pkg::KEY_IDX_W-1:0]        wr_index,
   input  logic [kps_pkg::TIME_W-1:0]           wr_time,
   input  logic signed [kps_pkg::POS_W-1:0]     wr_x,
   input  logic signed [kps_pkg::POS_W-1:0]     wr_y,
   input  logic signed [kps_pkg::POS_W-1:0]     wr_z,
   input  logic                                 scan_mode,
   input  logic [kps_pkg::TIME_W-1:0]           ref_time,
   input  kps_pkg::token_type                   tok_in,
   output kps_pkg::token_type                   tok_out,
   output kps_pkg::token_type                   key_rd
);

   logic [kps_pkg::TIME_W-1:0]       time_ff;
   logic signed [kps_pkg::POS_W-1:0] x_ff, y_ff, z_ff;
   logic                             valid_ff, valid_in;
   kps_pkg::token_type               tok_ff, tok_in_next;
   logic                             active, take;

   assign active = {1'b0, cell_id} < key_num;

   always_comb begin
      unique case (scan_mode)
         kps_pkg::SCAN_FROM: take = active && (time_ff <= ref_time) && (time_ff > tok_in.key_t);
         kps_pkg::SCAN_TO:   take = active && (time_ff > ref_time)
                                   && (!tok_in.found || (time_ff < tok_in.key_t));
         default:            take = 1'b0;
      endcase
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.key_t = time_ff;
         tok_in_next.x     = x_ff;
         tok_in_next.y     = y_ff;
         tok_in_next.z     = z_ff;
      end
   end

   assign valid_in = tok_in.valid;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_index == cell_id)) begin
         time_ff <= wr_time;
         x_ff    <= wr_x;
         y_ff    <= wr_y;
         z_ff    <= wr_z;
      end
      tok_ff <= tok_in_next;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = valid_ff;
      key_rd        = '{valid: 1'b0, found: 1'b0, key_t: time_ff, x: x_ff, y: y_ff, z: z_ff};
   end

endmodule

>>> rtl/kps_divider.sv
// kps_divider: restoring divider, one quotient bit per cycle
// depends on kps_pkg

module kps_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kps_pkg::NUM_W-1:0]     num,
   input  logic [kps_pkg::TIME_W-1:0]    den,
   output logic                          done,
   output logic [kps_pkg::NUM_W-1:0]     quo
);

   localparam int CNT_W = $clog2(kps_pkg::NUM_W + 1);

   logic [kps_pkg::TIME_W:0]     rem_ff, rem_in, rem_sh;
   logic [kps_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [kps_pkg::TIME_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in, done_ff, done_in;
   logic                         fits;

   always_comb begin
      rem_sh  = {rem_ff[kps_pkg::TIME_W-1:0], quo_ff[kps_pkg::NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(kps_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[kps_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> rtl/keyframe_position_sampler.sv
// keyframe_position_sampler: top level, key chain, scan control, weight and lerp
// depends on kps_pkg, kps_cell, kps_divider
//
// usage:
//   req channel carries requests: tuser is the opcode (write key or query),
//   tdata the key entry fields and the query time. a write request stores
//   one key in its cell and produces no response. a query request produces
//   one response on the rsp channel: position, time and sample kind.
//   csr port holds key_count at byte address 0, written with an apb access.
// operation:
//   a query sends a token twice down the chain of MAX_KEYS cells, one
//   cell per cycle (latest key at or before the query, then the nearest
//   later key), then a bit-serial divide for the weight and one shared
//   multiplier over three axes (a product step, then an add and saturate
//   step for each axis). exact hits, held keys and empty tables skip the
//   later steps and finish early.
// reset clears the control state and key_count; the key cells hold garbage
// until written. the finished response sits in an output register, so a
// stalled receiver does not block the next request; a second response waits
// in the engine until the register frees.

module keyframe_position_sampler (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [0:0]    req_tuser,   // [0] opcode
   input  logic [167:0]  req_tdata,   // key_index, key_time, key_x, key_y, key_z, query_time, pad
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [1:0]    rsp_tuser,   // [1:0] sample_kind
   output logic [127:0]  rsp_tdata,   // pos_x, pos_y, pos_z, result_time
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int TW = kps_pkg::TIME_W;
   localparam int PW = kps_pkg::POS_W;
   localparam int CW = kps_pkg::COUNT_W;
   localparam int NK = kps_pkg::MAX_KEYS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;
   localparam logic [2:0] ST_SCAN2 = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // request fields
   logic                          op;
   logic [kps_pkg::KEY_IDX_W-1:0] key_index;
   logic [TW-1:0]                 key_time, query_time;
   logic signed [PW-1:0]          key_x, key_y, key_z;

   assign op         = req_tuser[0];
   assign key_index  = req_tdata[5:0];
   assign key_time   = req_tdata[37:6];
   assign key_x      = req_tdata[69:38];
   assign key_y      = req_tdata[101:70];
   assign key_z      = req_tdata[133:102];
   assign query_time = req_tdata[165:134];

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, key_num;
   logic        req_acc, wr_en;

   // key count clamp, register port
   assign key_num    = (count_ff > CW'(NK)) ? CW'(NK) : count_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, count_ff};

   always_comb begin
      count_in = count_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         count_in = csr_pwdata[CW-1:0];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (op == kps_pkg::OP_WRITE);

   // scan chain
   kps_pkg::token_type chain_tok [NK+1];
   kps_pkg::token_type key_rd    [NK];
   logic               scan_mode;
   logic [TW-1:0]      ref_time;
   logic               launch_ff, launch_in;
   logic [TW-1:0]      q_ff, q_in;

   always_comb begin
      chain_tok[0]       = key_rd[0];
      chain_tok[0].valid = launch_ff;
      chain_tok[0].found = 1'b0;
   end

   for (genvar i = 0; i < NK; i++) begin : g_cell
      kps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (kps_pkg::KEY_IDX_W'(i)),
         .key_num   (key_num),
         .wr_en     (wr_en),
         .wr_index  (key_index),
         .wr_time   (key_time),
         .wr_x      (key_x),
         .wr_y      (key_y),
         .wr_z      (key_z),
         .scan_mode (scan_mode),
         .ref_time  (ref_time),
         .tok_in    (chain_tok[i]),
         .tok_out   (chain_tok[i+1]),
         .key_rd    (key_rd[i])
      );
   end

   // start and end keys
   logic [TW-1:0]        ta_ff, ta_in, tb_ff, tb_in;
   logic signed [PW-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [PW-1:0] ax_in, ay_in, az_in, bx_in, by_in, bz_in;

   assign scan_mode = (state_ff == ST_SCAN2) ? kps_pkg::SCAN_TO : kps_pkg::SCAN_FROM;
   assign ref_time  = (state_ff == ST_SCAN2) ? ta_ff : q_ff;

   // weight divider
   logic                       div_start, div_done;
   logic [kps_pkg::NUM_W-1:0]  div_num, div_quo;
   logic [TW-1:0]              span;
   logic                       diff_neg;
   logic [TW-1:0]              mdiff;

   assign diff_neg  = q_ff < ta_ff;
   assign mdiff     = diff_neg ? ta_ff - q_ff : q_ff - ta_ff;
   assign span      = (ta_ff < tb_ff) ? tb_ff - ta_ff : ta_ff - tb_ff;
   assign div_num   = {mdiff, 16'd0};

   kps_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (span),
      .done  (div_done),
      .quo   (div_quo)
   );

   // weight as sign and magnitude, saturated
   logic [TW-1:0] mw_ff, mw_in;
   logic          wneg_ff, wneg_in;

   // lerp, one axis at a time
   logic [1:0]            axis_ff, axis_in;
   logic                  ph_ff, ph_in;
   logic [63:0]           prod_ff, prod_in;
   logic                  pneg_ff, pneg_in;
   logic signed [PW-1:0]  a_ff, a_in, a_sel, b_sel;
   logic signed [PW:0]    d;
   logic [PW:0]           md;
   logic [64:0]           prod_full;
   logic [47:0]           sh;
   logic signed [49:0]    sum;
   logic signed [PW-1:0]  sat_sum;

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin a_sel = ax_ff; b_sel = bx_ff; end
         2'd1:    begin a_sel = ay_ff; b_sel = by_ff; end
         default: begin a_sel = az_ff; b_sel = bz_ff; end
      endcase
      d         = {b_sel[PW-1], b_sel} - {a_sel[PW-1], a_sel};
      md        = d[PW] ? -d : d;
      prod_full = {32'd0, md} * {33'd0, mw_ff};
      sh        = pneg_ff ? 48'((prod_ff + 64'hFFFF) >> 16) : 48'(prod_ff >> 16);
      sum       = {{18{a_ff[PW-1]}}, a_ff} + (pneg_ff ? -$signed({2'b00, sh})
                                                    : $signed({2'b00, sh}));
      if (sum > 50'sd2147483647)       sat_sum = 32'h7FFFFFFF;
      else if (sum < -50'sd2147483648) sat_sum = 32'h80000000;
      else                             sat_sum = sum[PW-1:0];
   end

   // results
   logic signed [PW-1:0] rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic [TW-1:0]        rt_ff, rt_in;
   logic [1:0]           rk_ff, rk_in;

   // output register
   logic                 ov_ff, ov_in;
   logic [127:0]         od_ff, od_in;
   logic [1:0]           ok_ff, ok_in;
   logic                 out_free;

   assign out_free = !ov_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      q_in      = q_ff;
      ta_in = ta_ff; tb_in = tb_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      div_start = 1'b0;
      mw_in   = mw_ff;
      wneg_in = wneg_ff;
      axis_in = axis_ff;
      ph_in   = ph_ff;
      prod_in = prod_ff;
      pneg_in = pneg_ff;
      a_in    = a_ff;
      rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      rt_in = rt_ff; rk_in = rk_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;
      ok_in = ok_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (op == kps_pkg::OP_QUERY)) begin
               q_in = query_time;
               if (key_num == '0) begin
                  rx_in = '0; ry_in = '0; rz_in = '0;
                  rt_in = query_time;
                  rk_in = kps_pkg::KIND_EMPTY;
                  state_in = ST_DONE;
               end else begin
                  launch_in = 1'b1;
                  state_in  = ST_SCAN1;
               end
            end
         end
         ST_SCAN1: begin
            if (chain_tok[NK].valid) begin
               ta_in = chain_tok[NK].key_t;
               ax_in = chain_tok[NK].x;
               ay_in = chain_tok[NK].y;
               az_in = chain_tok[NK].z;
               rx_in = chain_tok[NK].x;
               ry_in = chain_tok[NK].y;
               rz_in = chain_tok[NK].z;
               rt_in = chain_tok[NK].key_t;
               if (chain_tok[NK].key_t == q_ff) begin
                  rk_in    = kps_pkg::KIND_EXACT;
                  state_in = ST_DONE;
               end else begin
                  launch_in = 1'b1;
                  state_in  = ST_SCAN2;
               end
            end
         end
         ST_SCAN2: begin
            if (chain_tok[NK].valid) begin
               tb_in = chain_tok[NK].key_t;
               bx_in = chain_tok[NK].x;
               by_in = chain_tok[NK].y;
               bz_in = chain_tok[NK].z;
               if (chain_tok[NK].key_t == ta_ff) begin
                  rk_in    = kps_pkg::KIND_HOLD;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // start pulse on entry: tb is settled now
            if (ph_ff == 1'b0) begin
               div_start = 1'b1;
               ph_in     = 1'b1;
            end else if (div_done) begin
               if (diff_neg) begin
                  wneg_in = div_quo != '0;
                  mw_in   = (div_quo > 48'h80000000) ? 32'h80000000 : div_quo[TW-1:0];
               end else begin
                  wneg_in = 1'b0;
                  mw_in   = (div_quo > 48'h7FFFFFFF) ? 32'h7FFFFFFF : div_quo[TW-1:0];
               end
               ph_in    = 1'b0;
               axis_in  = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (ph_ff == 1'b0) begin
               prod_in = prod_full[63:0];
               pneg_in = d[PW] != wneg_ff;
               a_in    = a_sel;
               ph_in   = 1'b1;
            end else begin
               unique case (axis_ff)
                  2'd0:    rx_in = sat_sum;
                  2'd1:    ry_in = sat_sum;
                  default: rz_in = sat_sum;
               endcase
               ph_in = 1'b0;
               if (axis_ff == 2'd2) begin
                  rt_in    = q_ff;
                  rk_in    = kps_pkg::KIND_INTERP;
                  state_in = ST_DONE;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ov_in    = 1'b1;
               od_in    = {rt_ff, rz_ff, ry_ff, rx_ff};
               ok_in    = rk_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      ta_ff <= ta_in; tb_ff <= tb_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      mw_ff <= mw_in; wneg_ff <= wneg_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in; pneg_ff <= pneg_in; a_ff <= a_in;
      rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
      rt_ff <= rt_in; rk_ff <= rk_in;
      od_ff <= od_in; ok_ff <= ok_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         launch_ff <= 1'b0;
         ph_ff     <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         launch_ff <= launch_in;
         ph_ff     <= ph_in;
         ov_ff     <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ok_ff;

endmodule

>>> rtl/kps_checker.sv
// kps_checker: port-level assertions for keyframe_position_sampler, bound to the top level
// depends on kps_pkg and keyframe_position_sampler

module kps_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [1:0]   rsp_tuser,
   input logic [127:0] rsp_tdata
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // empty table gives zero position
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == kps_pkg::KIND_EMPTY) |-> (rsp_tdata[95:0] == 96'd0))
      else $error("empty result with nonzero position");

   // a query keeps the engine busy for the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == kps_pkg::OP_QUERY) |=> !req_tready)
      else $error("request taken while query in flight");

endmodule

bind keyframe_position_sampler kps_checker u_kps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/tb_keyframe_position_sampler.sv
// tb_keyframe_position_sampler: self-checking bench for the keyframe position sampler
// depends on kps_pkg and the rtl top level keyframe_position_sampler
`timescale 1ns / 100ps

module tb_keyframe_position_sampler;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [0:0]    req_tuser;   // [0] opcode
   logic [167:0]  req_tdata;   // key_index, key_time, key_x, key_y, key_z, query_time, pad
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [1:0]    rsp_tuser;   // [1:0] sample_kind
   logic [127:0]  rsp_tdata;   // pos_x, pos_y, pos_z, result_time
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [31:0]        t;
      logic [1:0]         kind;
   } sample_type;

   localparam logic [2:0] ADDR_KEY_COUNT = 3'd0;
   localparam int WATCHDOG_LIMIT = 200000;

   // local copy of the key table and count
   logic [31:0]        model_time [kps_pkg::MAX_KEYS];
   logic signed [31:0] model_pos  [kps_pkg::MAX_KEYS][3];
   int                 model_count;

   sample_type expected_samples[$];
   int  error_count;
   bit  hold_off_receiver;
   bit  stimulus_done;
   int  idle_cycles;

   keyframe_position_sampler dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fffffff;
      if (v < -96'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // one axis of the lerp: delta floored by the shift, sum saturated
   function automatic logic signed [31:0] lerp_axis(input logic signed [31:0] a,
         input logic signed [31:0] b, input logic signed [63:0] w);
      logic signed [95:0] d;
      logic signed [95:0] prod;
      d = 96'(b) - 96'(a);
      prod = d * 96'(w);
      return clamp32(96'(a) + (prod >>> 16));
   endfunction

   function automatic sample_type predict_sample(input logic [31:0] q);
      sample_type s;
      int n, from, to;
      bit found;
      logic [31:0] ta, tb, span;
      logic [63:0] mdiff, quo;
      logic signed [63:0] w;
      n = model_count > kps_pkg::MAX_KEYS ? kps_pkg::MAX_KEYS : model_count;
      s.t = q;
      s.x = 0; s.y = 0; s.z = 0;
      s.kind = kps_pkg::KIND_EMPTY;
      if (n == 0) return s;
      from = 0;
      for (int i = 0; i < n; i++)
         if (model_time[i] <= q && model_time[i] > model_time[from]) from = i;
      ta = model_time[from];
      s.x = model_pos[from][0]; s.y = model_pos[from][1]; s.z = model_pos[from][2];
      if (ta == q) begin
         s.t = ta; s.kind = kps_pkg::KIND_EXACT;
         return s;
      end
      to = 0;
      found = 0;
      for (int i = 0; i < n; i++)
         if (model_time[i] > ta && (!found || model_time[i] < model_time[to])) begin
            to = i; found = 1;
         end
      tb = model_time[to];
      if (ta == tb) begin
         s.t = ta; s.kind = kps_pkg::KIND_HOLD;
         return s;
      end
      span = ta < tb ? tb - ta : ta - tb;
      mdiff = q >= ta ? 64'(q - ta) : 64'(ta - q);
      quo = (mdiff << 16) / 64'(span);
      if (q < ta) w = quo > 64'h80000000 ? -64'sd2147483648 : -$signed(quo);
      else w = quo > 64'h7fffffff ? 64'sd2147483647 : $signed(quo);
      s.x = lerp_axis(model_pos[from][0], model_pos[to][0], w);
      s.y = lerp_axis(model_pos[from][1], model_pos[to][1], w);
      s.z = lerp_axis(model_pos[from][2], model_pos[to][2], w);
      s.t = q; s.kind = kps_pkg::KIND_INTERP;
      return s;
   endfunction

   // idle length in cycles: mostly none or short, a few long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      return r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60);
   endfunction

   // send one request, update the local table and queue the expected response
   task automatic send_request(input logic op, input logic [5:0] idx, input logic [31:0] kt,
         input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] kz,
         input logic [31:0] qt, input bit gaps);
      int gap;
      req_tuser <= op;
      req_tdata <= {8'h00, qt, kz, ky, kx, kt, idx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == kps_pkg::OP_WRITE) begin
         model_time[idx] = kt;
         model_pos[idx][0] = kx; model_pos[idx][1] = ky; model_pos[idx][2] = kz;
      end else begin
         expected_samples.push_back(predict_sample(qt));
      end
      @(negedge clock);
      if (gaps && $urandom_range(0, 3) != 0) begin
         gap = gap_length();
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic write_key(input int idx, input logic [31:0] kt, input bit gaps);
      send_request(kps_pkg::OP_WRITE, idx[5:0], kt, $urandom, $urandom, $urandom, $urandom,
                   gaps);
   endtask

   task automatic query_at(input logic [31:0] qt, input bit gaps);
      send_request(kps_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                   qt, gaps);
   endtask

   // wait for all responses plus engine latency, then write key_count
   task automatic set_key_count(input int count);
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_KEY_COUNT; csr_pwdata <= 32'(count);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      model_count = count & 32'h7f;
   endtask

   // query time biased toward key times and their neighbors
   function automatic logic [31:0] pick_query_time();
      int n, r;
      n = model_count > kps_pkg::MAX_KEYS ? kps_pkg::MAX_KEYS : model_count;
      r = $urandom_range(0, 9);
      if (n == 0 || r < 2) return $urandom;
      if (r < 5) return model_time[$urandom_range(0, n - 1)];
      return model_time[$urandom_range(0, n - 1)] + $urandom_range(0, 40000) - 20000;
   endfunction

   task automatic test_empty_table();
      query_at(32'h0000_0000, 0);
      query_at(32'hffff_ffff, 0);
      query_at($urandom, 0);
   endtask

   task automatic test_directed_keys();
      // extremes of every field; all 64 entries filled so any count is safe
      send_request(kps_pkg::OP_WRITE, 6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h0, 0, 0);
      send_request(kps_pkg::OP_WRITE, 6'd1, 32'h0003_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'hffff_ffff, 0, 0);
      send_request(kps_pkg::OP_WRITE, 6'd2, 32'h0003_0000, 32'h1, 32'h2, 32'h3, 0, 0);
      for (int i = 3; i < kps_pkg::MAX_KEYS; i++) write_key(i, $urandom, 0);
      send_request(kps_pkg::OP_WRITE, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
                   32'h8000_0000, 32'hffff_ffff, 0);
      set_key_count(1);
      query_at(32'h0001_0000, 0);   // exact hit
      query_at(32'h0002_0000, 0);   // single key holds
      set_key_count(3);
      query_at(32'h0002_0000, 0);   // interpolated midway between extreme positions
      query_at(32'h0000_0000, 0);   // before every key: extrapolates backward
      query_at(32'hffff_ffff, 0);   // after the last key: wraps to key 0
      query_at(32'h0003_0000, 0);   // exact hit on duplicate time
      set_key_count(kps_pkg::MAX_KEYS);
      query_at(32'hffff_ffff, 0);
      query_at(32'h0000_0001, 0);
      set_key_count(127);           // count above capacity clamps
      query_at($urandom, 0);
   endtask

   task automatic test_random_traffic();
      int count;
      for (int phase = 0; phase < 8; phase++) begin
         count = phase == 0 ? 2 : phase == 7 ? kps_pkg::MAX_KEYS : $urandom_range(0, 12);
         if (phase == 5) count = $urandom_range(65, 127);
         set_key_count(count);
         for (int i = 0; i < 120; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               // small spread of times gives close keys, duplicates and exact hits
               write_key($urandom_range(0, 63),
                         $urandom_range(0, 1) ? $urandom_range(0, 8) << 16 : $urandom, 1);
            end else begin
               query_at(pick_query_time(), 1);
            end
            if (i == 60 && phase == 2 && expected_samples.size() != 0) begin
               // sender pauses until all responses are back
               req_tvalid <= 1'b0;
               while (expected_samples.size() != 0) @(negedge clock);
            end
         end
      end
   endtask

   task automatic test_receiver_backpressure();
      set_key_count(8);
      hold_off_receiver = 1'b1;
      for (int i = 0; i < 12; i++) query_at(pick_query_time(), 0);
      req_tvalid <= 1'b0;
      while (hold_off_receiver) @(negedge clock);
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      error_count = 0; hold_off_receiver = 1'b0; stimulus_done = 1'b0;
      model_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_keys();
      test_receiver_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // receiver readiness: random stalls, plus a long counted hold-off on demand
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (hold_off_receiver) begin
            rsp_tready <= 1'b0;
            for (stall = 0; stall < 3000; stall++) @(negedge clock);
            hold_off_receiver = 1'b0;
         end else begin
            if ($urandom_range(0, 40) == 0) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 80)) @(negedge clock);
            end else begin
               rsp_tready <= $urandom_range(0, 3) != 0;
               @(negedge clock);
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      sample_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected response %h kind %0d", $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            e = expected_samples.pop_front();
            if (rsp_tdata[31:0] !== e.x || rsp_tdata[63:32] !== e.y ||
                rsp_tdata[95:64] !== e.z || rsp_tdata[127:96] !== e.t ||
                rsp_tuser !== e.kind) begin
               $display("%0t: mismatch expected x %h y %h z %h t %h kind %0d", $time,
                        e.x, e.y, e.z, e.t, e.kind);
               $display("%0t:          actual x %h y %h z %h t %h kind %0d", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tdata[127:96], rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted request or response and no register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule

>>> keyframe_position_sampler.f
rtl/kps_pkg.sv
rtl/kps_cell.sv
rtl/kps_divider.sv
rtl/keyframe_position_sampler.sv
rtl/kps_checker.sv
bench/tb_keyframe_position_sampler.sv
